@@ design/sparse_set_membership_macros.svh @@
// ---------------------------------------------------------------------------
// Sparse set membership assertion macros
// Shared property forms for the checks in the sparse set design.
// ---------------------------------------------------------------------------
`ifndef SPARSE_SET_MEMBERSHIP_MACROS_SVH
`define SPARSE_SET_MEMBERSHIP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ssm_pkg.sv @@
// ---------------------------------------------------------------------------
// ssm_pkg
// Types, codes and constants of the sparse set membership block.
// ---------------------------------------------------------------------------
package ssm_pkg;

   localparam int DOMAIN_MAX = 256;
   localparam int SLOT_W     = $clog2(DOMAIN_MAX);
   localparam int COUNT_W    = 9;
   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 8;
   localparam int CSR_IDX_W  = 4;

   typedef enum logic [2:0] {
      CMD_INSERT   = 3'd0,
      CMD_REMOVE   = 3'd1,
      CMD_CONTAINS = 3'd2,
      CMD_CLEAR    = 3'd3,
      CMD_READ     = 3'd4,
      CMD_REFILL   = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOWER_BOUND = 4'd0,
      REG_DOMAIN_SIZE = 4'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_FETCH,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [2:0]                cmd;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
   } req_type;

   typedef struct packed {
      logic                      present;
      logic signed [VALUE_W-1:0] element;
      logic [COUNT_W-1:0]        count;
      logic                      error;
   } rsp_type;

   // Control of one table: read port, write port and bulk refill
   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [SLOT_W-1:0] wr_data;
   } tbl_ctl_type;

   // Domain settings and refill request from the register file
   typedef struct packed {
      logic signed [VALUE_W-1:0] lower_bound;
      logic [COUNT_W-1:0]        size;
      logic                      write_pending;
      logic                      refill;
      logic [COUNT_W-1:0]        refill_size;
   } cfg_type;

   // Clamp a raw domain size to [1, DOMAIN_MAX]
   function automatic logic [COUNT_W-1:0] eff_size(input logic [COUNT_W-1:0] raw);
      logic [COUNT_W-1:0] res;
      res = raw;
      if (raw == '0) begin
         res = COUNT_W'(1);
      end else if (raw > COUNT_W'(DOMAIN_MAX)) begin
         res = COUNT_W'(DOMAIN_MAX);
      end
      return res;
   endfunction

endpackage

@@ design/ssm_table.sv @@
// ---------------------------------------------------------------------------
// ssm_table
// One slot table: synchronous RAM with a registered read and a valid bit
// per entry; an entry not written since the last refill reads as its
// own address (identity permutation).
// ---------------------------------------------------------------------------
module ssm_table (
   input  logic                         clock,
   input  logic                         reset,
   input  ssm_pkg::tbl_ctl_type         ctl,
   output logic [ssm_pkg::SLOT_W-1:0]   rd_data
);
   import ssm_pkg::*;

   logic [SLOT_W-1:0]     mem_ff [DOMAIN_MAX];
   logic [DOMAIN_MAX-1:0] valid_ff;
   logic [SLOT_W-1:0]     rd_q_ff;
   logic [SLOT_W-1:0]     rd_addr_ff;
   logic                  hit_ff;

   // Write and registered read of the RAM array
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff    <= mem_ff[ctl.rd_addr];
         rd_addr_ff <= ctl.rd_addr;
         hit_ff     <= valid_ff[ctl.rd_addr];
      end
   end

   // Drop all valid bits on refill, mark entries as they are written
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   // Fall back to identity for entries not written since refill
   assign rd_data = hit_ff ? rd_q_ff : rd_addr_ff;

endmodule

@@ design/ssm_ctrl.sv @@
// ---------------------------------------------------------------------------
// ssm_ctrl
// Command sequencer: looks up the position map, swaps slot pairs through
// the dense store and position map tables, keeps the member count and
// holds the result item in an output register.
// ---------------------------------------------------------------------------
`include "sparse_set_membership_macros.svh"

module ssm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  ssm_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ssm_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ssm_pkg::rsp_type              rsp_data,
   output logic                          idle,
   output ssm_pkg::tbl_ctl_type          dense_ctl,
   input  logic [ssm_pkg::SLOT_W-1:0]    dense_rd,
   output ssm_pkg::tbl_ctl_type          pmap_ctl,
   input  logic [ssm_pkg::SLOT_W-1:0]    pmap_rd
);
   import ssm_pkg::*;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] pend_ff, pend_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [SLOT_W-1:0]  off_ff, off_in;
   logic               in_dom_ff, in_dom_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  base_ff, base_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               out_free;
   logic signed [VALUE_W:0] diff;
   logic               member;
   logic               swap;
   logic [SLOT_W-1:0]  swap_base;
   logic [COUNT_W-1:0] count_new;
   logic               clear_tables;
   rsp_type            result;

   assign req_ready = (state_ff == ST_IDLE) && !cfg.write_pending;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idle      = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Offset of the request value from the lower bound
   assign diff = {req_data.value[VALUE_W-1], req_data.value}
               - {cfg.lower_bound[VALUE_W-1], cfg.lower_bound};

   // Membership of the looked-up slot
   assign member = {1'b0, pmap_rd} < count_ff;

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_W'(DOMAIN_MAX);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      cmd_ff      <= cmd_in;
      off_ff      <= off_in;
      in_dom_ff   <= in_dom_in;
      index_ff    <= index_in;
      slot_ff     <= slot_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Decode the held command against the looked-up slot
   always_comb begin
      result       = '0;
      result.count = count_ff;
      swap         = 1'b0;
      swap_base    = count_ff[SLOT_W-1:0];
      count_new    = count_ff;
      clear_tables = 1'b0;
      unique case (cmd_type'(cmd_ff))
         CMD_INSERT: begin
            if (!in_dom_ff) begin
               result.error = 1'b1;
            end else if (!member && (count_ff < COUNT_W'(DOMAIN_MAX))) begin
               swap      = 1'b1;
               swap_base = count_ff[SLOT_W-1:0];
               count_new = count_ff + COUNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (!in_dom_ff) begin
               result.error = 1'b1;
            end else if (member) begin
               swap      = 1'b1;
               count_new = count_ff - COUNT_W'(1);
               swap_base = count_new[SLOT_W-1:0];
            end
         end
         CMD_CONTAINS: begin
            if (!in_dom_ff) begin
               result.error = 1'b1;
            end else begin
               result.present = member;
            end
         end
         CMD_CLEAR: begin
            count_new = '0;
         end
         CMD_READ: begin
            if ({1'b0, index_ff} >= count_ff) begin
               result.error = 1'b1;
            end else begin
               result.element = cfg.lower_bound + VALUE_W'(dense_rd);
            end
         end
         CMD_REFILL: begin
            count_new    = cfg.size;
            clear_tables = 1'b1;
         end
         default: begin
            result.error = 1'b1;
         end
      endcase
      result.count = count_new;
   end

   // Next state, table accesses and result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      cmd_in       = cmd_ff;
      off_in       = off_ff;
      in_dom_in    = in_dom_ff;
      index_in     = index_ff;
      slot_in      = slot_ff;
      base_in      = base_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dense_ctl    = '0;
      pmap_ctl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // Take an item, issue map and dense reads
            if (accept) begin
               cmd_in           = req_data.cmd;
               in_dom_in        = !diff[VALUE_W]
                                && (diff[VALUE_W-1:0] < VALUE_W'(cfg.size));
               off_in           = diff[SLOT_W-1:0];
               index_in         = req_data.index;
               pmap_ctl.rd_en   = 1'b1;
               pmap_ctl.rd_addr = diff[SLOT_W-1:0];
               dense_ctl.rd_en  = 1'b1;
               dense_ctl.rd_addr = req_data.index[SLOT_W-1:0];
               state_in         = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // Start a swap, or finish the item here
            if (swap) begin
               dense_ctl.rd_en   = 1'b1;
               dense_ctl.rd_addr = swap_base;
               slot_in           = pmap_rd;
               base_in           = swap_base;
               pend_in           = count_new;
               state_in          = ST_FETCH;
            end else if (out_free) begin
               rsp_data_in     = result;
               rsp_valid_in    = 1'b1;
               count_in        = count_new;
               dense_ctl.clear = clear_tables;
               pmap_ctl.clear  = clear_tables;
               state_in        = ST_IDLE;
            end
         end
         ST_FETCH: begin
            // Move the boundary entry into the value's slot
            dense_ctl.wr_en   = 1'b1;
            dense_ctl.wr_addr = slot_ff;
            dense_ctl.wr_data = dense_rd;
            pmap_ctl.wr_en    = 1'b1;
            pmap_ctl.wr_addr  = dense_rd;
            pmap_ctl.wr_data  = slot_ff;
            state_in          = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Place the value at the boundary slot; repeats while stalled
            dense_ctl.wr_en   = 1'b1;
            dense_ctl.wr_addr = base_ff;
            dense_ctl.wr_data = off_ff;
            pmap_ctl.wr_en    = 1'b1;
            pmap_ctl.wr_addr  = off_ff;
            pmap_ctl.wr_data  = base_ff;
            if (out_free) begin
               rsp_data_in       = '0;
               rsp_data_in.count = pend_ff;
               rsp_valid_in      = 1'b1;
               count_in          = pend_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register write refills the set
      if (cfg.refill) begin
         count_in        = cfg.refill_size;
         dense_ctl.clear = 1'b1;
         pmap_ctl.clear  = 1'b1;
      end
   end

   `SSM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(DOMAIN_MAX), "member count above domain")
   `SSM_ASSERT_NEXT(a_accept_lookup, clock, reset, accept, state_ff == ST_LOOKUP, "accepted item skipped lookup")
   `SSM_ASSERT_NEXT(a_fetch_commit, clock, reset, state_ff == ST_FETCH, state_ff == ST_COMMIT && dense_ctl.wr_en && pmap_ctl.wr_en, "swap did not complete")
   `SSM_ASSERT_NEXT(a_refill_count, clock, reset, cfg.refill, count_ff == $past(cfg.refill_size), "refill lost member count")

endmodule

@@ design/sparse_set_membership.sv @@
// Sequencing: contains, read, clear, refill, error and no-op items go IDLE, LOOKUP,
//   IDLE; an insert or remove that swaps slots goes IDLE, LOOKUP, FETCH, COMMIT, IDLE.
// Flow: one item at a time, taken only in IDLE; a full reply register holds it in LOOKUP
//   or COMMIT; each table's single write port takes the two swap writes in FETCH, COMMIT.
// Reset: full set over [0, 255], identity tables via per-entry valid bits, no clearing
//   pass; writes to a known register and the refill command restore identity.
// ---------------------------------------------------------------------------
// sparse_set_membership
// Sparse set over a bounded integer domain: dense store and position map
// tables, command sequencer and the domain register file.
// ---------------------------------------------------------------------------
module sparse_set_membership (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ssm_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ssm_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssm_pkg::VALUE_W-1:0]      csr_wdata
);
   import ssm_pkg::*;

   logic signed [VALUE_W-1:0] lower_bound_ff, lower_bound_in;
   logic [COUNT_W-1:0]        size_ff, size_in;
   logic                      csr_fire;
   logic                      refill;
   logic [COUNT_W-1:0]        refill_size;
   logic                      ctrl_idle;
   cfg_type                   cfg;
   tbl_ctl_type               dense_ctl;
   tbl_ctl_type               pmap_ctl;
   logic [SLOT_W-1:0]         dense_rd;
   logic [SLOT_W-1:0]         pmap_rd;

   assign csr_ready = ctrl_idle;
   assign csr_fire  = csr_valid && csr_ready;

   // Decode register writes; a known register refills the set
   always_comb begin
      lower_bound_in = lower_bound_ff;
      size_in        = size_ff;
      refill         = 1'b0;
      refill_size    = size_ff;
      unique case (csr_index)
         REG_LOWER_BOUND: begin
            if (csr_fire) begin
               lower_bound_in = csr_wdata;
               refill         = 1'b1;
            end
         end
         REG_DOMAIN_SIZE: begin
            if (csr_fire) begin
               size_in     = eff_size(csr_wdata[COUNT_W-1:0]);
               refill_size = size_in;
               refill      = 1'b1;
            end
         end
         default: begin
            refill = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_bound_ff <= '0;
         size_ff        <= COUNT_W'(DOMAIN_MAX);
      end else begin
         lower_bound_ff <= lower_bound_in;
         size_ff        <= size_in;
      end
   end

   assign cfg.lower_bound   = lower_bound_ff;
   assign cfg.size          = size_ff;
   assign cfg.write_pending = csr_valid;
   assign cfg.refill        = refill;
   assign cfg.refill_size   = refill_size;

   ssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .idle      (ctrl_idle),
      .dense_ctl (dense_ctl),
      .dense_rd  (dense_rd),
      .pmap_ctl  (pmap_ctl),
      .pmap_rd   (pmap_rd)
   );

   ssm_table u_dense (
      .clock   (clock),
      .reset   (reset),
      .ctl     (dense_ctl),
      .rd_data (dense_rd)
   );

   ssm_table u_pmap (
      .clock   (clock),
      .reset   (reset),
      .ctl     (pmap_ctl),
      .rd_data (pmap_rd)
   );

endmodule

@@ tb/sv/tb_sparse_set_membership.sv @@
// ---------------------------------------------------------------------------
// tb_sparse_set_membership
// Self-checking bench for the sparse set block. A tracker object mirrors the
// dense store, the position map and the member count. It predicts one reply
// for every command taken by the block and checks the replies in order.
// Directed commands cover the corner cases. Random phases follow; all but the
// first set their own lower bound and domain size.
// ---------------------------------------------------------------------------
module tb_sparse_set_membership;
   import ssm_pkg::*;

   localparam logic [2:0]           CMD_SPARE_A      = 3'd6;
   localparam logic [2:0]           CMD_SPARE_B      = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_TOP = 4'd15;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_ITEMS = 100;
   localparam int PHASES      = 9;
   localparam int TAIL_CYCLES = 10;

   // Mirror of the set state plus the queue of replies still owed
   class set_tracker;
      logic [SLOT_W-1:0]         dense_slots [DOMAIN_MAX];
      logic [SLOT_W-1:0]         slot_of [DOMAIN_MAX];
      int                        members;
      logic signed [VALUE_W-1:0] lower_bound;
      logic [COUNT_W-1:0]        size_reg;
      rsp_type                   pending_replies [$];
      int                        errors;

      function new();
         lower_bound = '0;
         size_reg    = COUNT_W'(DOMAIN_MAX);
         errors      = 0;
         refill();
      endfunction

      // Domain size as the block uses it: at least one, at most the table depth
      function int span();
         if (size_reg == '0) begin
            return 1;
         end
         if (size_reg > COUNT_W'(DOMAIN_MAX)) begin
            return DOMAIN_MAX;
         end
         return int'(size_reg);
      endfunction

      function void refill();
         for (int k = 0; k < DOMAIN_MAX; k++) begin
            dense_slots[k] = SLOT_W'(k);
            slot_of[k]     = SLOT_W'(k);
         end
         members = span();
      endfunction

      // Exchange two dense slots and make the map follow both entries
      function void swap_slots(int a, int b);
         logic [SLOT_W-1:0] held;
         held           = dense_slots[a];
         dense_slots[a] = dense_slots[b];
         dense_slots[b] = held;
         slot_of[dense_slots[a]] = SLOT_W'(a);
         slot_of[dense_slots[b]] = SLOT_W'(b);
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
         if (idx == REG_LOWER_BOUND) begin
            lower_bound = data;
            refill();
         end else if (idx == REG_DOMAIN_SIZE) begin
            size_reg = data[COUNT_W-1:0];
            refill();
         end
      endfunction

      function void apply_command(req_type item);
         rsp_type           want;
         longint            offs;
         bit                in_domain;
         logic [SLOT_W-1:0] off;
         want      = '0;
         offs      = longint'($signed(item.value)) - longint'($signed(lower_bound));
         in_domain = (offs >= 0) && (offs < span());
         off       = in_domain ? offs[SLOT_W-1:0] : '0;
         case (item.cmd)
            CMD_INSERT: begin
               if (!in_domain) begin
                  want.error = 1'b1;
               end else if (slot_of[off] >= members && members < DOMAIN_MAX) begin
                  swap_slots(slot_of[off], members);
                  members++;
               end
            end
            CMD_REMOVE: begin
               if (!in_domain) begin
                  want.error = 1'b1;
               end else if (slot_of[off] < members) begin
                  members--;
                  swap_slots(slot_of[off], members);
               end
            end
            CMD_CONTAINS: begin
               if (!in_domain) begin
                  want.error = 1'b1;
               end else begin
                  want.present = (slot_of[off] < members);
               end
            end
            CMD_CLEAR: begin
               members = 0;
            end
            CMD_READ: begin
               if (item.index >= members) begin
                  want.error = 1'b1;
               end else begin
                  want.element = lower_bound + VALUE_W'(dense_slots[item.index]);
               end
            end
            CMD_REFILL: begin
               refill();
            end
            default: begin
               want.error = 1'b1;
            end
         endcase
         want.count = COUNT_W'(members);
         pending_replies.push_back(want);
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            errors++;
            $display("%0t: reply with no command outstanding, count %0d", $time, got.count);
            return;
         end
         want = pending_replies.pop_front();
         if (got.present !== want.present) begin
            errors++;
            $display("%0t: present expected %0b, got %0b", $time, want.present, got.present);
         end
         if (got.element !== want.element) begin
            errors++;
            $display("%0t: element expected %0d, got %0d", $time, want.element, got.element);
         end
         if (got.count !== want.count) begin
            errors++;
            $display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
         end
         if (got.error !== want.error) begin
            errors++;
            $display("%0t: error expected %0b, got %0b", $time, want.error, got.error);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [VALUE_W-1:0]    csr_wdata;

   set_tracker tracker;
   bit         steady_flow;
   bit         hold_replies;
   int         stall_cycles;

   sparse_set_membership dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Observe every handshake at the rising edge; trip the watchdog on no progress
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            tracker.apply_command(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            tracker.check_reply(rsp_data);
         end
         if (csr_valid && csr_ready) begin
            tracker.write_register(csr_index, csr_wdata);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Reply side: random back-pressure per item unless flow is steady, one long hold on request
   initial begin : reply_side
      int gap;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_replies) begin
            rsp_ready    <= 1'b0;
            hold_replies  = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            gap = steady_flow ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one command after a random gap (none when flow is steady) and hold it until taken
   task automatic push_item(input req_type item);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic push_cmd(input logic [2:0] cmd, input logic [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index);
      req_type item;
      item.cmd   = cmd;
      item.value = value;
      item.index = index;
      push_item(item);
   endtask

   // Drop valid and hold off until every reply owed has come back
   task automatic drain_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly in-domain values, some just outside the bounds, some anywhere
   function automatic req_type random_command();
      req_type item;
      int      pick;
      int      width;
      width = tracker.span();
      pick  = $urandom_range(0, 99);
      if (pick < 30) begin
         item.cmd = CMD_INSERT;
      end else if (pick < 60) begin
         item.cmd = CMD_REMOVE;
      end else if (pick < 78) begin
         item.cmd = CMD_CONTAINS;
      end else if (pick < 90) begin
         item.cmd = CMD_READ;
      end else if (pick < 94) begin
         item.cmd = CMD_CLEAR;
      end else if (pick < 97) begin
         item.cmd = CMD_REFILL;
      end else if (pick < 99) begin
         item.cmd = CMD_SPARE_A;
      end else begin
         item.cmd = CMD_SPARE_B;
      end
      pick = $urandom_range(0, 99);
      if (pick < 86) begin
         item.value = tracker.lower_bound + $urandom_range(0, width - 1);
      end else if (pick < 90) begin
         item.value = tracker.lower_bound - 1;
      end else if (pick < 94) begin
         item.value = tracker.lower_bound + width;
      end else begin
         item.value = $urandom;
      end
      if ($urandom_range(0, 9) == 0) begin
         item.index = INDEX_W'($urandom);
      end else begin
         item.index = INDEX_W'($urandom_range(0, width - 1));
      end
      return item;
   endfunction

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      steady_flow  = 1'b0;
      hold_replies = 1'b0;
      stall_cycles = 0;
      tracker      = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed corners on the full reset domain [0, 255]
      push_cmd(CMD_CONTAINS, 32'd0, 8'd0);
      push_cmd(CMD_INSERT, 32'd5, 8'hFF);
      push_cmd(CMD_INSERT, 32'd255, 8'h00);
      push_cmd(CMD_READ, 32'hFFFF_FFFF, 8'd255);
      push_cmd(CMD_READ, 32'd0, 8'd0);
      push_cmd(CMD_CONTAINS, 32'd256, 8'd0);
      push_cmd(CMD_CONTAINS, 32'hFFFF_FFFF, 8'd0);
      push_cmd(CMD_REMOVE, 32'd10, 8'd0);
      push_cmd(CMD_REMOVE, 32'd10, 8'd0);
      push_cmd(CMD_CONTAINS, 32'd10, 8'd0);
      push_cmd(CMD_READ, 32'd0, 8'd255);
      push_cmd(CMD_INSERT, 32'd10, 8'd0);
      push_cmd(CMD_CLEAR, 32'd0, 8'd0);
      push_cmd(CMD_READ, 32'd0, 8'd0);
      push_cmd(CMD_REMOVE, 32'd7, 8'd0);
      push_cmd(CMD_INSERT, 32'h7FFF_FFFF, 8'd0);
      push_cmd(CMD_INSERT, 32'h8000_0000, 8'd0);
      push_cmd(CMD_INSERT, 32'd200, 8'd0);
      push_cmd(CMD_INSERT, 32'd3, 8'd0);
      push_cmd(CMD_READ, 32'd0, 8'd1);
      push_cmd(CMD_REMOVE, 32'd200, 8'd0);
      push_cmd(CMD_READ, 32'd0, 8'd0);
      push_cmd(CMD_SPARE_A, 32'd3, 8'd0);
      push_cmd(CMD_SPARE_B, 32'd3, 8'd0);
      push_cmd(CMD_REFILL, 32'd0, 8'd0);
      drain_replies();

      // Random phases; each after the first sets its own domain setting
      for (int ph = 0; ph < PHASES; ph++) begin
         steady_flow = (ph % 3 == 2);
         case (ph)
            1: begin
               write_csr(REG_LOWER_BOUND, 32'hFFFF_FFFB);
               write_csr(REG_DOMAIN_SIZE, 32'd16);
               hold_replies = 1'b1;
            end
            2: begin
               // Domain runs past the top of the signed range
               write_csr(REG_LOWER_BOUND, 32'h7FFF_FF80);
               write_csr(REG_DOMAIN_SIZE, 32'd256);
            end
            3: begin
               write_csr(REG_LOWER_BOUND, 32'h8000_0000);
               write_csr(REG_DOMAIN_SIZE, 32'd1);
            end
            4: begin
               // Zero size clamps to a single value
               write_csr(REG_LOWER_BOUND, $urandom);
               write_csr(REG_DOMAIN_SIZE, $urandom & 32'hFFFF_FE00);
            end
            5: begin
               // Oversize clamps to the table depth
               write_csr(REG_LOWER_BOUND, $urandom);
               write_csr(REG_DOMAIN_SIZE, ($urandom & 32'hFFFF_FE00) | 32'h1FF);
            end
            6: begin
               write_csr(REG_UNMAPPED_TOP, $urandom);
               write_csr(REG_LOWER_BOUND, 32'd100);
               write_csr(REG_DOMAIN_SIZE, 32'd40);
            end
            7: begin
               write_csr(REG_LOWER_BOUND, $urandom);
               write_csr(REG_DOMAIN_SIZE, ($urandom & 32'hFFFF_FE00) | $urandom_range(1, 256));
               write_csr(CSR_IDX_W'($urandom_range(REG_DOMAIN_SIZE + 1, REG_UNMAPPED_TOP - 1)),
                         $urandom);
            end
            8: begin
               write_csr(REG_LOWER_BOUND, 32'h7FFF_FFFF);
               write_csr(REG_DOMAIN_SIZE, 32'd2);
            end
            default: begin
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Pause the sender mid-phase until the block has answered everything
            if (ph == 4 && n == PHASE_ITEMS / 2) begin
               drain_replies();
            end
            push_item(random_command());
         end
         drain_replies();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
